// File: sv/assert_macros.svh
// assertion macros used by the limiter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: sv/kswl_pkg.sv
// types and constants of the keyed sliding window limiter
`default_nettype none
package kswl_pkg;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned WIN_W = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd60000;

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_EVICT = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [KEY_W-1:0] key_hash;
        logic [TIME_W-1:0] now_ms;
    } t_req;

    typedef struct packed {
        logic accepted;
        logic table_full;
        logic [6:0] live_count;
    } t_resp;
endpackage
`default_nettype wire

// File: sv/keyed_sliding_window_limiter_core.sv
// top level of the keyed sliding window limiter
// usage:
// requests enter on the push/full side as {command, key_hash, now_ms}; results
// leave on the empty/pop side as {accepted, table_full, live_count}, one per
// request, in order. a two-entry request queue decouples the front from the
// sequencer, and a two-entry result queue lets the block go on while a result
// waits. requests are handled one at a time. check looks up the key, drops its
// aged stamps one by one and decides; query reads every stamp logged for the
// key; evict walks all NUM_KEYS slots and drops the aged stamps of each valid
// one; clear empties the key table. the cost is set by the single-port stamp
// ram, read one stamp at a time.
// configuration: i_cfg_we writes register i_cfg_idx (0 limit, 1 window) at once;
// write only while idle.
// reset (synchronous, active low) empties the key table and queues, limit 0,
// window 60000; no clearing pass is needed. if pop is held low the result queue
// fills, the sequencer waits, and full rises once the request queue is full.
`default_nettype none
`include "assert_macros.svh"
module keyed_sliding_window_limiter_core #(
    parameter int unsigned NUM_KEYS = 16,
    parameter int unsigned LOG_DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    input  wire kswl_pkg::t_req              i_req,
    output logic                             full,
    output logic                             empty,
    input  wire logic                        pop,
    output kswl_pkg::t_resp                  o_resp,
    input  wire logic                        i_cfg_we,
    input  wire logic [kswl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kswl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kswl_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic [WIN_W-1:0] r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic rq_empty, rq_take, rs_full, rs_push;
    t_req rq_data;
    t_resp rs_data;

    kswl_fifo #(.WIDTH($bits(t_req)), .DEPTH(2)) u_req_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(i_req), .o_full(full),
        .i_pop(rq_take), .o_empty(rq_empty), .o_data(rq_data)
    );

    kswl_engine #(.NUM_KEYS(NUM_KEYS), .LOG_DEPTH(LOG_DEPTH)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_limit(r_limit), .i_window(r_window),
        .i_req_valid(!rq_empty), .i_req(rq_data), .o_req_take(rq_take),
        .i_resp_full(rs_full), .o_resp_push(rs_push), .o_resp(rs_data)
    );

    kswl_fifo #(.WIDTH($bits(t_resp)), .DEPTH(2)) u_resp_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(rs_push), .i_data(rs_data), .o_full(rs_full),
        .i_pop(pop), .o_empty(empty), .o_data(o_resp)
    );

    `ASSERT_NEVER(a_no_take_empty, i_clk, i_rst_n, rq_take && rq_empty)
    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, rs_push && rs_full)
    `ASSERT_CLK(a_full_flag, i_clk, i_rst_n,
                (rs_data.table_full && rs_push) |-> !rs_data.accepted)
    `ASSERT_CLK(a_take_no_push, i_clk, i_rst_n, rq_take |-> !rs_push)
endmodule
`default_nettype wire

// File: sv/kswl_ram.sv
// generic single port ram with registered read
`default_nettype none
module kswl_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: sv/kswl_fifo.sv
// small fifo for requests and results
`default_nettype none
module kswl_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic do_push, do_pop;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_data = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
        if (do_push) begin
            r_q[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: sv/kswl_engine.sv
// back part: key table, stamp logs and command sequencer
`default_nettype none
module kswl_engine #(
    parameter int unsigned NUM_KEYS = 16,
    parameter int unsigned LOG_DEPTH = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [6:0]              i_limit,
    input  wire logic [31:0]             i_window,
    input  wire logic                    i_req_valid,
    input  wire kswl_pkg::t_req          i_req,
    output logic                         o_req_take,
    input  wire logic                    i_resp_full,
    output logic                         o_resp_push,
    output kswl_pkg::t_resp              o_resp
);
    import kswl_pkg::*;

    localparam int unsigned SW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int unsigned HW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
    localparam int unsigned MD = NUM_KEYS * LOG_DEPTH;
    localparam int unsigned MW = (MD > 1) ? $clog2(MD) : 1;
    localparam int unsigned XW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOK, ST_PRUNE_RD, ST_PRUNE_CHK, ST_DECIDE,
        ST_Q_RD, ST_Q_CHK, ST_EV_NEXT, ST_RESP
    } t_state;

    t_state r_state;
    logic [NUM_KEYS-1:0] r_valid;
    logic [KEY_W-1:0] r_key [NUM_KEYS];
    logic [HW-1:0] r_head [NUM_KEYS];
    logic [CW-1:0] r_cnt [NUM_KEYS];
    t_req r_req;
    logic [TIME_W-1:0] r_cutoff;
    logic [SW-1:0] r_slot;
    logic r_evict;
    logic r_ev_first;
    logic [CW-1:0] r_idx, r_live;
    t_resp r_resp;

    logic mem_we;
    logic [MW-1:0] mem_addr;
    logic [TIME_W-1:0] mem_rdata;
    logic [HW-1:0] pos;

    kswl_ram #(.WIDTH(TIME_W), .DEPTH(MD)) u_log (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(r_req.now_ms),
        .o_rdata(mem_rdata)
    );

    // lookup and free slot search over the small key table
    logic hit, free_found;
    logic [SW-1:0] hit_slot, free_slot;
    always_comb begin
        hit = 1'b0;
        free_found = 1'b0;
        hit_slot = '0;
        free_slot = '0;
        for (int s = NUM_KEYS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_key[s] == r_req.key_hash) begin
                hit = 1'b1;
                hit_slot = SW'(s);
            end
            if (!r_valid[s]) begin
                free_found = 1'b1;
                free_slot = SW'(s);
            end
        end
    end

    // circular position helper: head plus offset modulo depth
    logic [HW:0] pos_sum;
    logic [CW-1:0] cur_cnt;
    logic [HW-1:0] cur_head;
    assign cur_cnt = r_cnt[r_slot];
    assign cur_head = r_head[r_slot];
    always_comb begin
        logic [CW-1:0] off;
        unique case (r_state)
            ST_DECIDE: off = cur_cnt;
            ST_Q_RD, ST_Q_CHK: off = r_idx;
            default: off = '0;
        endcase
        pos_sum = (HW+1)'(cur_head) + (HW+1)'(off);
        pos = (pos_sum >= (HW+1)'(LOG_DEPTH)) ? HW'(pos_sum - (HW+1)'(LOG_DEPTH))
                                               : HW'(pos_sum);
    end
    if (LOG_DEPTH > 1) begin : g_addr
        logic [MW-1:0] base;
        assign base = MW'(r_slot) * MW'(LOG_DEPTH);
        assign mem_addr = base + MW'(pos);
    end else begin : g_addr1
        assign mem_addr = MW'(r_slot);
    end

    logic refuse, room;
    assign refuse = (i_limit != '0) && (XW'(cur_cnt) >= XW'(i_limit));
    assign room = cur_cnt < CW'(LOG_DEPTH);
    assign mem_we = (r_state == ST_DECIDE) && !refuse && room;
    assign o_req_take = (r_state == ST_IDLE) && i_req_valid;
    assign o_resp_push = (r_state == ST_RESP) && !i_resp_full;
    assign o_resp = r_resp;

    logic [TIME_W-1:0] cut;
    assign cut = (i_req.now_ms >= TIME_W'(i_window)) ? i_req.now_ms - TIME_W'(i_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            for (int s = 0; s < NUM_KEYS; s++) begin
                r_head[s] <= '0;
                r_cnt[s] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_cutoff <= cut;
                        r_resp <= '{accepted: 1'b1, table_full: 1'b0, live_count: '0};
                        r_slot <= '0;
                        r_idx <= '0;
                        r_live <= '0;
                        unique case (t_cmd'(i_req.command))
                            CMD_CHECK, CMD_QUERY: r_state <= ST_LOOK;
                            CMD_EVICT: begin
                                r_evict <= 1'b1;
                                r_ev_first <= 1'b1;
                                r_state <= ST_EV_NEXT;
                            end
                            CMD_CLEAR: begin
                                r_valid <= '0;
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_LOOK: begin
                    r_evict <= 1'b0;
                    if (t_cmd'(r_req.command) == CMD_QUERY) begin
                        if (hit) begin
                            r_slot <= hit_slot;
                            r_state <= ST_Q_RD;
                        end else begin
                            r_state <= ST_RESP;
                        end
                    end else if (hit) begin
                        r_slot <= hit_slot;
                        r_state <= ST_PRUNE_RD;
                    end else if (free_found) begin
                        r_slot <= free_slot;
                        r_valid[free_slot] <= 1'b1;
                        r_key[free_slot] <= r_req.key_hash;
                        r_head[free_slot] <= '0;
                        r_cnt[free_slot] <= '0;
                        r_state <= ST_PRUNE_RD;
                    end else begin
                        r_resp <= '{accepted: 1'b0, table_full: 1'b1, live_count: '0};
                        r_state <= ST_RESP;
                    end
                end
                ST_PRUNE_RD: begin
                    // ram read of the oldest stamp is in flight
                    if (cur_cnt == '0) begin
                        r_state <= r_evict ? ST_EV_NEXT : ST_DECIDE;
                    end else begin
                        r_state <= ST_PRUNE_CHK;
                    end
                end
                ST_PRUNE_CHK: begin
                    if (mem_rdata < r_cutoff) begin
                        r_head[r_slot] <= (cur_head == HW'(LOG_DEPTH - 1)) ? '0
                                                                           : cur_head + 1'b1;
                        r_cnt[r_slot] <= cur_cnt - 1'b1;
                        r_state <= ST_PRUNE_RD;
                    end else begin
                        r_state <= r_evict ? ST_EV_NEXT : ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (refuse) begin
                        r_resp <= '{accepted: 1'b0, table_full: 1'b0, live_count: 7'(cur_cnt)};
                    end else if (room) begin
                        r_cnt[r_slot] <= cur_cnt + 1'b1;
                        r_resp <= '{accepted: 1'b1, table_full: 1'b0,
                                    live_count: 7'(cur_cnt + 1'b1)};
                    end else begin
                        r_resp <= '{accepted: 1'b1, table_full: 1'b0, live_count: 7'(cur_cnt)};
                    end
                    r_state <= ST_RESP;
                end
                ST_Q_RD: begin
                    if (r_idx == cur_cnt) begin
                        r_resp <= '{accepted: (i_limit == '0) ||
                                             (XW'(r_live) < XW'(i_limit)),
                                    table_full: 1'b0, live_count: 7'(r_live)};
                        r_state <= ST_RESP;
                    end else begin
                        r_state <= ST_Q_CHK;
                    end
                end
                ST_Q_CHK: begin
                    if (mem_rdata >= r_cutoff) begin
                        r_live <= r_live + 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                    r_state <= ST_Q_RD;
                end
                ST_EV_NEXT: begin
                    // walk every slot; first entry comes in with slot zero unvisited
                    r_ev_first <= 1'b0;
                    if (!r_ev_first && r_slot == SW'(NUM_KEYS - 1)) begin
                        r_state <= ST_RESP;
                    end else begin
                        if (!r_ev_first) begin
                            r_slot <= r_slot + 1'b1;
                        end
                        r_state <= ST_EV_NEXT;
                        if (r_valid[r_ev_first ? r_slot : SW'(r_slot + 1'b1)]) begin
                            r_state <= ST_PRUNE_RD;
                        end
                    end
                end
                ST_RESP: begin
                    if (!i_resp_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_keyed_sliding_window_limiter_core.sv
// self-checking testbench of the keyed sliding window limiter core
`timescale 1ns / 100ps
`default_nettype none
module tb_keyed_sliding_window_limiter_core;
    import kswl_pkg::*;

    localparam int unsigned NKEYS = 16;
    localparam int unsigned DEPTH = 64;
    localparam longint unsigned CYCLE_LIMIT = 20_000_000;

    // limiter predictor with its own key table and stamp logs
    class limiter_scoreboard;
        bit [LIMIT_W-1:0] limit;
        bit [WIN_W-1:0] window;
        bit used[NKEYS];
        bit [KEY_W-1:0] keys[NKEYS];
        bit [TIME_W-1:0] stamps[NKEYS][DEPTH];
        int unsigned head[NKEYS];
        int unsigned count[NKEYS];
        t_resp pending[$];
        int unsigned errors;

        function void wipe();
            for (int s = 0; s < NKEYS; s++) begin
                used[s] = 0;
                head[s] = 0;
                count[s] = 0;
            end
        endfunction

        function void reset_state();
            limit = '0;
            window = WINDOW_RESET;
            errors = 0;
            pending.delete();
            wipe();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_LIMIT) limit = val[LIMIT_W-1:0];
            else window = val;
        endfunction

        function int find_slot(bit [KEY_W-1:0] k);
            for (int s = 0; s < NKEYS; s++)
                if (used[s] && keys[s] == k) return s;
            return NKEYS;
        endfunction

        function void drop_aged(int s, bit [TIME_W-1:0] cut);
            while (count[s] > 0 && stamps[s][head[s]] < cut) begin
                head[s] = (head[s] + 1) % DEPTH;
                count[s]--;
            end
        endfunction

        function void note_request(t_req r);
            t_resp o;
            bit [TIME_W-1:0] cut;
            int s;
            o.accepted = 1'b1;
            o.table_full = 1'b0;
            o.live_count = '0;
            cut = (r.now_ms >= TIME_W'(window)) ? r.now_ms - TIME_W'(window) : '0;
            case (t_cmd'(r.command))
                CMD_CHECK: begin
                    s = find_slot(r.key_hash);
                    if (s == NKEYS) begin
                        for (s = 0; s < NKEYS; s++)
                            if (!used[s]) break;
                        if (s < NKEYS) begin
                            used[s] = 1;
                            keys[s] = r.key_hash;
                            head[s] = 0;
                            count[s] = 0;
                        end
                    end
                    if (s == NKEYS) begin
                        o.accepted = 1'b0;
                        o.table_full = 1'b1;
                    end else begin
                        drop_aged(s, cut);
                        if (limit != 0 && count[s] >= limit) o.accepted = 1'b0;
                        else if (count[s] < DEPTH) begin
                            stamps[s][(head[s] + count[s]) % DEPTH] = r.now_ms;
                            count[s]++;
                        end
                        o.live_count = 7'(count[s]);
                    end
                end
                CMD_QUERY: begin
                    int unsigned live;
                    s = find_slot(r.key_hash);
                    if (s < NKEYS) begin
                        live = 0;
                        for (int i = 0; i < count[s]; i++)
                            if (stamps[s][(head[s] + i) % DEPTH] >= cut) live++;
                        o.live_count = 7'(live);
                        o.accepted = (limit == 0 || live < limit);
                    end
                end
                CMD_EVICT: begin
                    for (int k = 0; k < NKEYS; k++)
                        if (used[k]) drop_aged(k, cut);
                end
                default: wipe();
            endcase
            pending = {pending, o};
        endfunction

        function void check_result(t_resp got);
            t_resp want;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.table_full !== want.table_full) begin
                $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
                errors++;
            end
            if (got.live_count !== want.live_count) begin
                $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    t_req i_req = '0;
    logic full;
    logic empty;
    logic pop = 1'b0;
    t_resp o_resp;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    limiter_scoreboard board;
    longint unsigned cycles = 0;
    bit [TIME_W-1:0] clock_ms = '0;
    bit stall_out = 1'b0;
    bit [KEY_W-1:0] key_pool[24];
    int pop_wait = 0;

    keyed_sliding_window_limiter_core dut (
        .i_clk, .i_rst_n, .push, .i_req, .full, .empty, .pop, .o_resp,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random gaps between pops, long hold-off while stall_out is set
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n) begin
            if (pop && !empty) begin
                board.check_result(o_resp);
                pop_wait = pick_gap();
            end else if (pop_wait > 0) begin
                pop_wait--;
            end
            pop <= !stall_out && (pop_wait == 0);
        end
    end

    task automatic send(t_cmd c, bit [KEY_W-1:0] k, bit [TIME_W-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req <= '{command: c, key_hash: k, now_ms: t};
        do @(posedge i_clk); while (full);
        board.note_request('{command: c, key_hash: k, now_ms: t});
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    task automatic drain(int tail);
        push <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int pool);
        int r;
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            c = (r < 70) ? CMD_CHECK : (r < 90) ? CMD_QUERY : (r < 98) ? CMD_EVICT : CMD_CLEAR;
            if ($urandom_range(0, 9) < 7) clock_ms += $urandom_range(0, 40);
            else if ($urandom_range(0, 30) == 0) clock_ms += $urandom;
            send(c, (r % 50 == 7) ? $urandom : key_pool[$urandom_range(0, pool - 1)], clock_ms);
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unknown-key query under limit 0, unlimited saturation at log depth
        send(CMD_QUERY, 32'hFFFF_FFFF, '0);
        for (int i = 0; i < 3; i++) send(CMD_CHECK, '0, '0);
        send(CMD_CHECK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send(CMD_QUERY, '0, 48'hFFFF_FFFF_FFFF);
        send(CMD_EVICT, '0, 48'hFFFF_FFFF_FFFF);
        send(CMD_CLEAR, '0, 48'hFFFF_FFFF_FFFF);
        drain(40);
        for (int i = 0; i < 70; i++) send(CMD_CHECK, 32'h5A5A_A5A5, 48'd100);
        send(CMD_QUERY, 32'h5A5A_A5A5, 48'd100);
        // table full
        for (int i = 0; i < 17; i++) send(CMD_CHECK, 32'(i), 48'd100);
        send(CMD_CLEAR, '0, 48'd100);
        drain(40);

        // limit equal to the log depth, zero window
        write_reg(REG_LIMIT, 64);
        write_reg(REG_WINDOW, 0);
        for (int i = 0; i < 66; i++) send(CMD_CHECK, 32'h1234, 48'(200 + i / 30));
        send(CMD_QUERY, 32'h1234, 48'd202);
        drain(40);

        // limit of one, time going backwards for the query
        write_reg(REG_LIMIT, 1);
        write_reg(REG_WINDOW, 10);
        send(CMD_CHECK, 32'h77, 48'd1000);
        send(CMD_CHECK, 32'h77, 48'd1005);
        send(CMD_QUERY, 32'h77, 48'd1020);
        send(CMD_QUERY, 32'h77, 48'd990);
        send(CMD_CHECK, 32'h77, 48'd1011);
        drain(40);

        // back pressure: hold off the receiver while requests keep coming
        stall_out = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                stall_out = 1'b0;
            end
            random_phase(30, 6);
        join
        drain(40);

        write_reg(REG_LIMIT, 3);
        write_reg(REG_WINDOW, 50);
        random_phase(450, 8);
        drain(1200);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        random_phase(350, 20);
        drain(1200);
        write_reg(REG_LIMIT, 8);
        write_reg(REG_WINDOW, 200);
        random_phase(500, 12);
        drain(1200);
        write_reg(REG_LIMIT, 2);
        write_reg(REG_WINDOW, 1);
        random_phase(400, 24);
        drain(1200);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+sv
sv/kswl_pkg.sv
sv/kswl_ram.sv
sv/kswl_fifo.sv
sv/kswl_engine.sv
sv/keyed_sliding_window_limiter_core.sv
tb/sv/tb_keyed_sliding_window_limiter_core.sv
